@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MPD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define MPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define MPD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define MPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/mpd_pkg.sv @@
package mpd_pkg;

   // default field format
   localparam int DefValueWidth   = 48;
   localparam int DefFractionBits = 32;

   // cells per wide multiply (one digit of the second operand per cell)
   localparam int MulStages = 8;

   // register widths
   localparam int MassW  = 33;
   localparam int GravW  = 37;
   localparam int ResW   = 39;
   localparam int IndW   = 33;
   localparam int ForceW = 26;
   localparam int RefW   = 29;

   // register port
   localparam int CsrAddrW = 6;
   localparam int CsrDataW = 64;

   localparam logic [MassW-1:0]  MassReset  = 33'd214748365;
   localparam logic [GravW-1:0]  GravReset  = 37'd42133629174;
   localparam logic [ResW-1:0]   ResReset   = 39'd42949672960;
   localparam logic [IndW-1:0]   IndReset   = 33'd429496730;
   localparam logic [ForceW-1:0] ForceReset = 26'd429497;
   localparam logic [RefW-1:0]   RefReset   = 29'd42949673;

   typedef enum logic [2:0] {
      CSR_BALL_MASS          = 3'd0,
      CSR_GRAVITY            = 3'd1,
      CSR_COIL_RESISTANCE    = 3'd2,
      CSR_NOMINAL_INDUCTANCE = 3'd3,
      CSR_FORCE_CONSTANT     = 3'd4,
      CSR_REFERENCE_GAP      = 3'd5
   } csr_index_type;

endpackage

@@ rtl/maglev_plant_derivative.sv @@
// Maglev plant derivatives. Takes one word per cycle (gap, velocity, coil
// current, drive voltage) and returns gap rate, acceleration and current
// rate, saturated, with a flag on tuser. Fully pipelined: sustained rate is
// one word per clock while rsp_tready does not stall the output; the depth
// is dominated by the two restoring divider cell chains, one quotient bit per
// cell. The user must write registers over the register port only while
// the block is idle, which it does not enforce; they take effect at once.
`include "assert_macros.svh"

module maglev_plant_derivative import mpd_pkg::*; #(
   parameter int VALUE_WIDTH   = DefValueWidth,
   parameter int FRACTION_BITS = DefFractionBits
) (
   input  logic clock,
   input  logic reset,
   // input stream
   input  logic req_tvalid,
   output logic req_tready,
   // gap, gap_velocity, coil_current, drive_voltage
   input  logic [((4*VALUE_WIDTH+7)>>3)*8-1:0] req_tdata,
   // result stream
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // gap_rate, gap_accel, current_rate
   output logic [((3*VALUE_WIDTH+7)>>3)*8-1:0] rsp_tdata,
   // saturated
   output logic [0:0] rsp_tuser,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   localparam int VW   = VALUE_WIDTH;
   localparam int FB   = FRACTION_BITS;
   localparam int LAT  = MulStages;
   localparam int OW   = ((3*VALUE_WIDTH+7)>>3)*8;
   localparam int Y2W  = 2 * VW;
   localparam int RIW  = ResW + VW;
   localparam int L0W  = IndW + RefW;
   localparam int N1W  = ((VW + FB > RIW) ? VW + FB : RIW) + 1;
   localparam int N2W  = N1W + Y2W;
   localparam int LBW  = L0W + Y2W;
   localparam int SW   = ((N2W > LBW) ? N2W : LBW) + 1;
   localparam int CNW  = Y2W + ForceW;
   localparam int ANW  = CNW + FB;
   localparam int MDW  = Y2W + MassW;
   localparam int LDW  = L0W + VW;
   localparam int QW   = ((VW > GravW) ? VW : GravW) + 2;
   localparam int LS   = 4 + 2 * LAT + QW;

   localparam longint unsigned YMinRaw =
      ((64'd1 << FRACTION_BITS) + 64'd500000) / 64'd1000000;
   localparam logic [VW-1:0] YMinV   = (YMinRaw == 0) ? VW'(1) : VW'(YMinRaw);
   localparam logic [QW-1:0] MaxPosQ = (QW'(1) << (VW - 1)) - QW'(1);
   localparam logic [QW-1:0] MinMagQ = QW'(1) << (VW - 1);
   localparam logic [VW-1:0] MaxPosV = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] MinNegV = {1'b1, {(VW-1){1'b0}}};

   // ---------------- registers ----------------
   logic [MassW-1:0]  mass_ff,  mass_in;
   logic [GravW-1:0]  grav_ff,  grav_in;
   logic [ResW-1:0]   res_ff,   res_in;
   logic [IndW-1:0]   ind_ff,   ind_in;
   logic [ForceW-1:0] force_ff, force_in;
   logic [RefW-1:0]   ref_ff,   ref_in;
   logic              csr_wr;
   csr_index_type     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[CsrAddrW-1:3]);

   always_comb begin
      mass_in  = mass_ff;
      grav_in  = grav_ff;
      res_in   = res_ff;
      ind_in   = ind_ff;
      force_in = force_ff;
      ref_in   = ref_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_BALL_MASS:          mass_in  = csr_pwdata[MassW-1:0];
            CSR_GRAVITY:            grav_in  = csr_pwdata[GravW-1:0];
            CSR_COIL_RESISTANCE:    res_in   = csr_pwdata[ResW-1:0];
            CSR_NOMINAL_INDUCTANCE: ind_in   = csr_pwdata[IndW-1:0];
            CSR_FORCE_CONSTANT:     force_in = csr_pwdata[ForceW-1:0];
            CSR_REFERENCE_GAP:      ref_in   = csr_pwdata[RefW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff  <= MassReset;
         grav_ff  <= GravReset;
         res_ff   <= ResReset;
         ind_ff   <= IndReset;
         force_ff <= ForceReset;
         ref_ff   <= RefReset;
      end else begin
         mass_ff  <= mass_in;
         grav_ff  <= grav_in;
         res_ff   <= res_in;
         ind_ff   <= ind_in;
         force_ff <= force_in;
         ref_ff   <= ref_in;
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_BALL_MASS:          csr_prdata = CsrDataW'(mass_ff);
         CSR_GRAVITY:            csr_prdata = CsrDataW'(grav_ff);
         CSR_COIL_RESISTANCE:    csr_prdata = CsrDataW'(res_ff);
         CSR_NOMINAL_INDUCTANCE: csr_prdata = CsrDataW'(ind_ff);
         CSR_FORCE_CONSTANT:     csr_prdata = CsrDataW'(force_ff);
         CSR_REFERENCE_GAP:      csr_prdata = CsrDataW'(ref_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic          en;
   logic [LS-1:0] vld_ff, vld_in;
   logic          last_vld;
   logic          out_vld_ff, out_vld_in, out_load;

   assign last_vld   = vld_ff[LS-1];
   assign en         = !last_vld || !out_vld_ff || rsp_tready;
   assign req_tready = en;
   assign vld_in     = {vld_ff[LS-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= vld_in;
   end

   function automatic logic [VW-1:0] mag_of(input logic [VW-1:0] v);
      logic [VW-1:0] neg_v;
      neg_v = -v;
      return v[VW-1] ? neg_v : v;
   endfunction

   // ---------------- stage 1: unpack, split signs, clamp gap ----------------
   logic [VW-1:0] gap_w, dy_w, cur_w, volt_w, gmag;
   logic [VW-1:0] y_ff, y_in, imag_ff, imag_in, vmag_ff, vmag_in;
   logic [VW-1:0] dymag_ff, dymag_in, dyraw_ff, dyraw_in;
   logic          ineg_ff, ineg_in, vneg_ff, vneg_in, dyneg_ff, dyneg_in;

   assign gap_w    = req_tdata[0 +: VW];
   assign dy_w     = req_tdata[VW +: VW];
   assign cur_w    = req_tdata[2*VW +: VW];
   assign volt_w   = req_tdata[3*VW +: VW];
   assign gmag     = mag_of(gap_w);
   assign y_in     = (gap_w[VW-1] || gmag < YMinV) ? YMinV : gmag;
   assign imag_in  = mag_of(cur_w);
   assign ineg_in  = cur_w[VW-1];
   assign vmag_in  = mag_of(volt_w);
   assign vneg_in  = volt_w[VW-1];
   assign dymag_in = mag_of(dy_w);
   assign dyneg_in = dy_w[VW-1];
   assign dyraw_in = dy_w;

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff     <= y_in;
         imag_ff  <= imag_in;
         ineg_ff  <= ineg_in;
         vmag_ff  <= vmag_in;
         vneg_ff  <= vneg_in;
         dymag_ff <= dymag_in;
         dyneg_ff <= dyneg_in;
         dyraw_ff <= dyraw_in;
      end
   end

   // ---------------- first multiply level ----------------
   logic [Y2W-1:0] y2_w, i2_w, dyi_w;
   logic [RIW-1:0] ri_w;
   logic [L0W-1:0] l0y0_w;
   logic [VW-1:0]  vmag_d, y_d;
   logic [2:0]     sg_d;

   mpd_mul #(.AW(VW), .BW(VW), .LAT(LAT)) u_y2 (
      .clock(clock), .en(en), .a(y_ff), .b(y_ff), .p(y2_w));
   mpd_mul #(.AW(VW), .BW(VW), .LAT(LAT)) u_i2 (
      .clock(clock), .en(en), .a(imag_ff), .b(imag_ff), .p(i2_w));
   mpd_mul #(.AW(VW), .BW(VW), .LAT(LAT)) u_dyi (
      .clock(clock), .en(en), .a(dymag_ff), .b(imag_ff), .p(dyi_w));
   mpd_mul #(.AW(VW), .BW(ResW), .LAT(LAT)) u_ri (
      .clock(clock), .en(en), .a(imag_ff), .b(res_ff), .p(ri_w));
   mpd_mul #(.AW(IndW), .BW(RefW), .LAT(LAT)) u_l0y0 (
      .clock(clock), .en(en), .a(ind_ff), .b(ref_ff), .p(l0y0_w));

   mpd_delay #(.W(VW), .DEPTH(LAT)) u_dvmag (
      .clock(clock), .en(en), .din(vmag_ff), .dout(vmag_d));
   mpd_delay #(.W(VW), .DEPTH(LAT)) u_dy (
      .clock(clock), .en(en), .din(y_ff), .dout(y_d));
   // vneg, ineg, sign of the inductance-slope term (negative when dy*i > 0)
   mpd_delay #(.W(3), .DEPTH(LAT)) u_dsg1 (
      .clock(clock), .en(en), .din({!(dyneg_ff ^ ineg_ff), ineg_ff, vneg_ff}),
      .dout(sg_d));

   // ---------------- stage P: V*2^F - R*i as sign and magnitude ----------------
   logic [N1W-1:0] ea1, eb1, n1mag_ff, n1mag_in;
   logic           sa1, sb1, n1neg_ff, n1neg_in;
   logic [Y2W-1:0] y2p_ff, i2p_ff, dyip_ff;
   logic [L0W-1:0] l0y0p_ff;
   logic [VW-1:0]  yp_ff;
   logic           sbp_ff;

   assign ea1 = N1W'(vmag_d) << FB;
   assign eb1 = N1W'(ri_w);
   assign sa1 = sg_d[0];
   assign sb1 = !sg_d[1];

   always_comb begin
      if (sa1 == sb1) begin
         n1mag_in = ea1 + eb1;
         n1neg_in = sa1;
      end else if (ea1 >= eb1) begin
         n1mag_in = ea1 - eb1;
         n1neg_in = sa1;
      end else begin
         n1mag_in = eb1 - ea1;
         n1neg_in = sb1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1mag_ff <= n1mag_in;
         n1neg_ff <= n1neg_in;
         y2p_ff   <= y2_w;
         i2p_ff   <= i2_w;
         dyip_ff  <= dyi_w;
         l0y0p_ff <= l0y0_w;
         yp_ff    <= y_d;
         sbp_ff   <= sg_d[2];
      end
   end

   // ---------------- second multiply level ----------------
   logic [CNW-1:0] cn_w;
   logic [MDW-1:0] md_w;
   logic [N2W-1:0] n2_w;
   logic [LBW-1:0] lb_w;
   logic [LDW-1:0] ld_w;
   logic [1:0]     sg2_d;

   mpd_mul #(.AW(Y2W), .BW(ForceW), .LAT(LAT)) u_cn (
      .clock(clock), .en(en), .a(i2p_ff), .b(force_ff), .p(cn_w));
   mpd_mul #(.AW(Y2W), .BW(MassW), .LAT(LAT)) u_md (
      .clock(clock), .en(en), .a(y2p_ff), .b(mass_ff), .p(md_w));
   mpd_mul #(.AW(N1W), .BW(Y2W), .LAT(LAT)) u_n2 (
      .clock(clock), .en(en), .a(n1mag_ff), .b(y2p_ff), .p(n2_w));
   mpd_mul #(.AW(Y2W), .BW(L0W), .LAT(LAT)) u_lb (
      .clock(clock), .en(en), .a(dyip_ff), .b(l0y0p_ff), .p(lb_w));
   mpd_mul #(.AW(L0W), .BW(VW), .LAT(LAT)) u_ld (
      .clock(clock), .en(en), .a(l0y0p_ff), .b(yp_ff), .p(ld_w));

   mpd_delay #(.W(2), .DEPTH(LAT)) u_dsg2 (
      .clock(clock), .en(en), .din({sbp_ff, n1neg_ff}), .dout(sg2_d));

   // ---------------- stage S: current numerator, accel numerator ----------------
   logic [SW-1:0]  ea2, eb2, smag_ff, smag_in;
   logic           sneg_ff, sneg_in;
   logic [ANW-1:0] an_ff;
   logic [MDW-1:0] md_ff;
   logic [LDW-1:0] ld_ff;

   assign ea2 = SW'(n2_w);
   assign eb2 = SW'(lb_w);

   always_comb begin
      if (sg2_d[0] == sg2_d[1]) begin
         smag_in = ea2 + eb2;
         sneg_in = sg2_d[0];
      end else if (ea2 >= eb2) begin
         smag_in = ea2 - eb2;
         sneg_in = sg2_d[0];
      end else begin
         smag_in = eb2 - ea2;
         sneg_in = sg2_d[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         smag_ff <= smag_in;
         sneg_ff <= sneg_in;
         an_ff   <= ANW'(cn_w) << FB;
         md_ff   <= md_w;
         ld_ff   <= ld_w;
      end
   end

   // ---------------- dividers ----------------
   logic [QW-1:0] qa, qc;
   logic          ha, hc, sneg_d;
   logic [VW-1:0] rate_d;

   mpd_div #(.NW(ANW), .DW(MDW), .QW(QW)) u_div_acc (
      .clock(clock), .en(en), .n(an_ff), .d(md_ff), .q(qa), .huge(ha));
   mpd_div #(.NW(SW), .DW(LDW), .QW(QW)) u_div_cur (
      .clock(clock), .en(en), .n(smag_ff), .d(ld_ff), .q(qc), .huge(hc));

   mpd_delay #(.W(1), .DEPTH(QW + 1)) u_dsneg (
      .clock(clock), .en(en), .din(sneg_ff), .dout(sneg_d));
   mpd_delay #(.W(VW), .DEPTH(LS - 1)) u_drate (
      .clock(clock), .en(en), .din(dyraw_ff), .dout(rate_d));

   // ---------------- saturation and output word ----------------
   function automatic logic [VW:0] clip(input logic neg, input logic [QW-1:0] mag,
                                        input logic huge);
      logic [QW-1:0] neg_mag;
      logic [VW:0]   res;
      neg_mag = QW'(0) - mag;
      if (!neg) begin
         res = (huge || mag > MaxPosQ) ? {1'b1, MaxPosV} : {1'b0, mag[VW-1:0]};
      end else if (huge || mag > MinMagQ) begin
         res = {1'b1, MinNegV};
      end else begin
         res = {1'b0, neg_mag[VW-1:0]};
      end
      return res;
   endfunction

   logic [QW-1:0] gq;
   logic [VW:0]   ra, rc;
   logic [VW-1:0] rate_ff, accel_ff, cur_ff;
   logic          sat_ff;

   assign gq = QW'(grav_ff);

   always_comb begin
      if (!ha && qa <= gq) ra = clip(1'b0, gq - qa, 1'b0);
      else                 ra = clip(1'b1, ha ? '0 : qa - gq, ha);
      rc = clip(sneg_d && (qc != '0 || hc), qc, hc);
   end

   assign out_load   = rsp_tready || !out_vld_ff;
   assign out_vld_in = out_load ? last_vld : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= out_vld_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rate_ff  <= rate_d;
         accel_ff <= ra[VW-1:0];
         cur_ff   <= rc[VW-1:0];
         sat_ff   <= ra[VW] | rc[VW];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = OW'({cur_ff, accel_ff, rate_ff});
   assign rsp_tuser  = sat_ff;

   // ---------------- assertions ----------------
   `MPD_ASSERT_IMPLY(a_stall_blocks_input, clock, reset,
      last_vld && out_vld_ff && !rsp_tready, !req_tready)
   `MPD_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, !req_tready, $stable(last_vld))
   `MPD_ASSERT_IMPLY(a_sat_at_limit, clock, reset, out_vld_ff && sat_ff,
      accel_ff == MaxPosV || accel_ff == MinNegV || cur_ff == MaxPosV || cur_ff == MinNegV)

endmodule

@@ rtl/mpd_delay.sv @@
module mpd_delay import mpd_pkg::*; #(
   parameter int W     = 1,
   parameter int DEPTH = MulStages
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [DEPTH];
   logic [W-1:0] tap_in [DEPTH];

   // shift line, advances with the pipeline
   always_comb begin
      tap_in[0] = din;
      for (int k = 1; k < DEPTH; k++) tap_in[k] = tap_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DEPTH; k++) tap_ff[k] <= tap_in[k];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

@@ rtl/mpd_mul.sv @@
module mpd_mul import mpd_pkg::*; #(
   parameter int AW  = 8,
   parameter int BW  = 8,
   parameter int LAT = MulStages
) (
   input  logic             clock,
   input  logic             en,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] p
);

   localparam int DGW = (BW + LAT - 1) / LAT;
   localparam int PBW = DGW * LAT;
   localparam int PW  = AW + BW;
   localparam int XW  = AW + DGW;

   logic [AW-1:0]  a_ff   [LAT];
   logic [AW-1:0]  a_in   [LAT];
   logic [PBW-1:0] b_ff   [LAT];
   logic [PBW-1:0] b_in   [LAT];
   logic [PW-1:0]  acc_ff [LAT];
   logic [PW-1:0]  acc_in [LAT];

   // each cell adds one digit's partial product and passes on
   for (genvar k = 0; k < LAT; k++) begin : g_cell
      logic [AW-1:0]  a_src;
      logic [PBW-1:0] b_src;
      logic [PW-1:0]  acc_src;
      logic [XW-1:0]  part;
      if (k == 0) begin : g_first
         assign a_src   = a;
         assign b_src   = PBW'(b);
         assign acc_src = '0;
      end else begin : g_next
         assign a_src   = a_ff[k-1];
         assign b_src   = b_ff[k-1];
         assign acc_src = acc_ff[k-1];
      end
      assign part      = XW'(a_src) * XW'(b_src[k*DGW +: DGW]);
      assign a_in[k]   = a_src;
      assign b_in[k]   = b_src;
      assign acc_in[k] = acc_src + (PW'(part) << (k * DGW));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < LAT; k++) begin
            a_ff[k]   <= a_in[k];
            b_ff[k]   <= b_in[k];
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   assign p = acc_ff[LAT-1];

endmodule

@@ rtl/mpd_div.sv @@
module mpd_div import mpd_pkg::*; #(
   parameter int NW = 8,
   parameter int DW = 8,
   parameter int QW = MulStages
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] n,
   input  logic [DW-1:0] d,
   output logic [QW-1:0] q,
   output logic          huge
);

   localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

   // range check: quotient overflows QW bits, or divide by zero of nonzero
   logic          h0_in, h0_ff, z0_in, z0_ff;
   logic [NW-1:0] r0_ff;
   logic [DW-1:0] d0_ff;

   assign z0_in = (d == '0);
   assign h0_in = z0_in ? (n != '0) : (CW'(n) >= (CW'(d) << QW));

   always_ff @(posedge clock) begin
      if (en) begin
         h0_ff <= h0_in;
         z0_ff <= z0_in;
         r0_ff <= n;
         d0_ff <= d;
      end
   end

   logic [NW-1:0] r_ff [QW];
   logic [NW-1:0] r_in [QW];
   logic [DW-1:0] d_ff [QW];
   logic [DW-1:0] d_in [QW];
   logic [QW-1:0] q_ff [QW];
   logic [QW-1:0] q_in [QW];
   logic          h_ff [QW];
   logic          h_in [QW];
   logic          z_ff [QW];
   logic          z_in [QW];

   // restoring cells, one quotient bit each, msb first
   for (genvar k = 0; k < QW; k++) begin : g_cell
      localparam int Bit = QW - 1 - k;
      logic [NW-1:0] r_src;
      logic [DW-1:0] d_src;
      logic [QW-1:0] q_src;
      logic          h_src, z_src, ge;
      logic [CW-1:0] ds, diff;
      if (k == 0) begin : g_first
         assign r_src = r0_ff;
         assign d_src = d0_ff;
         assign q_src = '0;
         assign h_src = h0_ff;
         assign z_src = z0_ff;
      end else begin : g_next
         assign r_src = r_ff[k-1];
         assign d_src = d_ff[k-1];
         assign q_src = q_ff[k-1];
         assign h_src = h_ff[k-1];
         assign z_src = z_ff[k-1];
      end
      assign ds      = CW'(d_src) << Bit;
      assign diff    = CW'(r_src) - ds;
      assign ge      = CW'(r_src) >= ds;
      assign r_in[k] = ge ? diff[NW-1:0] : r_src;
      assign q_in[k] = q_src | (ge ? (QW'(1) << Bit) : '0);
      assign d_in[k] = d_src;
      assign h_in[k] = h_src;
      assign z_in[k] = z_src;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            r_ff[k] <= r_in[k];
            d_ff[k] <= d_in[k];
            q_ff[k] <= q_in[k];
            h_ff[k] <= h_in[k];
            z_ff[k] <= z_in[k];
         end
      end
   end

   assign q    = z_ff[QW-1] ? '0 : q_ff[QW-1];
   assign huge = h_ff[QW-1];

endmodule
